FILE: rtl/circular_elevator_request_picker_core_defines.svh
// Assertion macros shared by the request picker RTL.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef CIRCULAR_ELEVATOR_REQUEST_PICKER_CORE_DEFINES_SVH
`define CIRCULAR_ELEVATOR_REQUEST_PICKER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define CERP_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CERP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CERP_ASSERT(lbl, clk, rst, prop, msg)
`define CERP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

FILE: rtl/cerp_pkg.sv
`default_nettype none

package cerp_pkg;

   localparam int CAPACITY = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int KEY_W    = 64;
   localparam int TAG_W    = 16;
   localparam int STAMP_W  = 32;
   localparam int OCC_W    = 7;

   typedef logic [IDX_W-1:0]   idx_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [KEY_W-1:0]   key_type;
   typedef logic [TAG_W-1:0]   tag_type;
   typedef logic [STAMP_W-1:0] stamp_type;
   typedef logic [OCC_W-1:0]   occ_type;

   typedef enum logic [1:0] {
      STATUS_PUSHED = 2'd0,
      STATUS_SERVED = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   // one stored request
   typedef struct packed {
      key_type   key;
      tag_type   tag;
      stamp_type stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

FILE: rtl/cerp_ram.sv
`default_nettype none

// simple dual-port RAM, one write and one registered read per cycle
module cerp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/circular_elevator_request_picker_core.sv
// Push: the valid bits are walked from slot 0 upward; the first free slot takes the request.
// Pop: one RAM read per entry through the read, register and fold stages, then a pick.
//   A refused push or an empty pop goes straight to the result.
// One transaction in flight: the next is taken the cycle after the result registers, even
//   while that result still waits on rsp_stall; a held result delays the next one.
// Synchronous active-high reset empties the store, zeroes head and stamp counter; RAM uncleared.
`default_nettype none

`include "circular_elevator_request_picker_core_defines.svh"

module circular_elevator_request_picker_core (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic                       req_action,
   input  wire logic [cerp_pkg::KEY_W-1:0] req_request_key,
   input  wire logic [cerp_pkg::TAG_W-1:0] req_request_tag,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic [cerp_pkg::KEY_W-1:0]      rsp_served_key,
   output logic [cerp_pkg::TAG_W-1:0]      rsp_served_tag,
   output logic [cerp_pkg::OCC_W-1:0]      rsp_occupancy
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUSH,
      ST_POP,
      ST_PICK,
      ST_DONE
   } state_type;

   // Control state
   state_type                      state_ff, state_in;
   logic [cerp_pkg::CAPACITY-1:0]  valid_ff, valid_in;
   cerp_pkg::count_type            fill_ff, fill_in;
   cerp_pkg::stamp_type            counter_ff, counter_in;
   cerp_pkg::key_type              head_ff, head_in;
   cerp_pkg::count_type            idx_ff, idx_in;
   logic                           rd_go_ff, rd_go_in;
   logic                           s2_go_ff, s2_go_in;
   logic                           any_have_ff, any_have_in;
   logic                           up_have_ff, up_have_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Payload held for the transaction in flight
   cerp_pkg::key_type              key_ff, key_in;
   cerp_pkg::tag_type              tag_ff, tag_in;
   logic                           rd_hit_ff, rd_hit_in;
   cerp_pkg::key_type              s2_key_ff, s2_key_in;
   cerp_pkg::tag_type              s2_tag_ff, s2_tag_in;
   cerp_pkg::stamp_type            s2_age_ff, s2_age_in;
   logic                           s2_ge_ff, s2_ge_in;
   cerp_pkg::idx_type              s2_idx_ff, s2_idx_in;
   cerp_pkg::idx_type              rd_idx_ff, rd_idx_in;
   cerp_pkg::key_type              any_key_ff, any_key_in;
   cerp_pkg::tag_type              any_tag_ff, any_tag_in;
   cerp_pkg::stamp_type            any_age_ff, any_age_in;
   cerp_pkg::idx_type              any_idx_ff, any_idx_in;
   cerp_pkg::key_type              up_key_ff, up_key_in;
   cerp_pkg::tag_type              up_tag_ff, up_tag_in;
   cerp_pkg::stamp_type            up_age_ff, up_age_in;
   cerp_pkg::idx_type              up_idx_ff, up_idx_in;
   cerp_pkg::status_type           res_status_ff, res_status_in;
   cerp_pkg::key_type              res_key_ff, res_key_in;
   cerp_pkg::tag_type              res_tag_ff, res_tag_in;
   cerp_pkg::status_type           rsp_status_ff, rsp_status_in;
   cerp_pkg::key_type              rsp_key_ff, rsp_key_in;
   cerp_pkg::tag_type              rsp_tag_ff, rsp_tag_in;
   cerp_pkg::occ_type              rsp_occ_ff, rsp_occ_in;

   // RAM port signals
   logic                           ram_wr_en;
   cerp_pkg::idx_type              ram_wr_addr;
   cerp_pkg::entry_type            ram_wr_data;
   logic                           ram_rd_en;
   cerp_pkg::idx_type              ram_rd_addr;
   logic [cerp_pkg::ENTRY_W-1:0]   ram_rd_raw;
   cerp_pkg::entry_type            ram_rd_data;

   logic                           req_accept;
   logic                           push_slot_free;
   logic                           scan_issuing;
   logic                           beats_any;
   logic                           beats_up;

   // Key, tag and insertion stamp of every slot live in one RAM; valid bits are flops.
   cerp_ram #(
      .WIDTH (cerp_pkg::ENTRY_W),
      .DEPTH (cerp_pkg::CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   assign ram_rd_data = cerp_pkg::entry_type'(ram_rd_raw);

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign push_slot_free = !valid_ff[idx_ff[cerp_pkg::IDX_W-1:0]];
   assign scan_issuing   = (idx_ff != cerp_pkg::count_type'(cerp_pkg::CAPACITY));

   // Ordering against the running winners: smaller key first, older entry on a tie.
   assign beats_any = !any_have_ff || (s2_key_ff < any_key_ff) ||
                      ((s2_key_ff == any_key_ff) && (s2_age_ff > any_age_ff));
   assign beats_up  = s2_ge_ff && (!up_have_ff || (s2_key_ff < up_key_ff) ||
                      ((s2_key_ff == up_key_ff) && (s2_age_ff > up_age_ff)));

   always_comb begin
      state_in      = state_ff;
      valid_in      = valid_ff;
      fill_in       = fill_ff;
      counter_in    = counter_ff;
      head_in       = head_ff;
      idx_in        = idx_ff;
      rd_go_in      = 1'b0;
      s2_go_in      = 1'b0;
      any_have_in   = any_have_ff;
      up_have_in    = up_have_ff;
      rsp_valid_in  = rsp_valid_ff;
      key_in        = key_ff;
      tag_in        = tag_ff;
      rd_hit_in     = rd_hit_ff;
      rd_idx_in     = rd_idx_ff;
      s2_key_in     = s2_key_ff;
      s2_tag_in     = s2_tag_ff;
      s2_age_in     = s2_age_ff;
      s2_ge_in      = s2_ge_ff;
      s2_idx_in     = s2_idx_ff;
      any_key_in    = any_key_ff;
      any_tag_in    = any_tag_ff;
      any_age_in    = any_age_ff;
      any_idx_in    = any_idx_ff;
      up_key_in     = up_key_ff;
      up_tag_in     = up_tag_ff;
      up_age_in     = up_age_ff;
      up_idx_in     = up_idx_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_tag_in    = res_tag_ff;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_tag_in    = rsp_tag_ff;
      rsp_occ_in    = rsp_occ_ff;

      ram_wr_en         = 1'b0;
      ram_wr_addr       = idx_ff[cerp_pkg::IDX_W-1:0];
      ram_wr_data.key   = key_ff;
      ram_wr_data.tag   = tag_ff;
      ram_wr_data.stamp = counter_ff;
      ram_rd_en         = 1'b0;
      ram_rd_addr       = idx_ff[cerp_pkg::IDX_W-1:0];

      // Drop the result once the receiver takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               key_in      = req_request_key;
               tag_in      = req_request_tag;
               idx_in      = '0;
               any_have_in = 1'b0;
               up_have_in  = 1'b0;
               res_key_in  = '0;
               res_tag_in  = '0;
               if (req_action == cerp_pkg::ACTION_PUSH) begin
                  if (fill_ff == cerp_pkg::count_type'(cerp_pkg::CAPACITY)) begin
                     res_status_in = cerp_pkg::STATUS_FULL;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_PUSH;
                  end
               end else begin
                  if (fill_ff == '0) begin
                     res_status_in = cerp_pkg::STATUS_EMPTY;
                     state_in      = ST_DONE;
                  end else begin
                     state_in = ST_POP;
                  end
               end
            end
         end

         ST_PUSH: begin
            // Walk the valid bits upward; the first free slot takes the request.
            if (push_slot_free) begin
               ram_wr_en     = 1'b1;
               valid_in[idx_ff[cerp_pkg::IDX_W-1:0]] = 1'b1;
               counter_in    = counter_ff + 1'b1;
               fill_in       = fill_ff + 1'b1;
               res_status_in = cerp_pkg::STATUS_PUSHED;
               state_in      = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         ST_POP: begin
            // Stage 1: issue one RAM read per slot, carrying its valid bit along.
            if (scan_issuing) begin
               ram_rd_en = 1'b1;
               rd_go_in  = 1'b1;
               rd_hit_in = valid_ff[idx_ff[cerp_pkg::IDX_W-1:0]];
               rd_idx_in = idx_ff[cerp_pkg::IDX_W-1:0];
               idx_in    = idx_ff + 1'b1;
            end
            // Stage 2: register the entry, its age and whether it lies at or above the head.
            if (rd_go_ff) begin
               s2_go_in  = rd_hit_ff;
               s2_key_in = ram_rd_data.key;
               s2_tag_in = ram_rd_data.tag;
               s2_age_in = counter_ff - ram_rd_data.stamp;
               s2_ge_in  = (ram_rd_data.key >= head_ff);
               s2_idx_in = rd_idx_ff;
            end
            // Stage 3: fold into the overall and the upward winners.
            if (s2_go_ff) begin
               if (beats_any) begin
                  any_have_in = 1'b1;
                  any_key_in  = s2_key_ff;
                  any_tag_in  = s2_tag_ff;
                  any_age_in  = s2_age_ff;
                  any_idx_in  = s2_idx_ff;
               end
               if (beats_up) begin
                  up_have_in = 1'b1;
                  up_key_in  = s2_key_ff;
                  up_tag_in  = s2_tag_ff;
                  up_age_in  = s2_age_ff;
                  up_idx_in  = s2_idx_ff;
               end
            end
            if (!scan_issuing && !rd_go_ff && !s2_go_ff) begin
               state_in = ST_PICK;
            end
         end

         ST_PICK: begin
            // Serve upward if anything lies at or above the head, else wrap to the lowest key.
            res_status_in = cerp_pkg::STATUS_SERVED;
            fill_in       = fill_ff - 1'b1;
            if (up_have_ff) begin
               res_key_in           = up_key_ff;
               res_tag_in           = up_tag_ff;
               head_in              = up_key_ff;
               valid_in[up_idx_ff]  = 1'b0;
            end else begin
               res_key_in           = any_key_ff;
               res_tag_in           = any_tag_ff;
               head_in              = any_key_ff;
               valid_in[any_idx_ff] = 1'b0;
            end
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Hold the result until the output register is free.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_key_in    = res_key_ff;
               rsp_tag_in    = res_tag_ff;
               rsp_occ_in    = cerp_pkg::occ_type'(fill_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      tag_ff        <= tag_in;
      rd_hit_ff     <= rd_hit_in;
      rd_idx_ff     <= rd_idx_in;
      s2_key_ff     <= s2_key_in;
      s2_tag_ff     <= s2_tag_in;
      s2_age_ff     <= s2_age_in;
      s2_ge_ff      <= s2_ge_in;
      s2_idx_ff     <= s2_idx_in;
      any_key_ff    <= any_key_in;
      any_tag_ff    <= any_tag_in;
      any_age_ff    <= any_age_in;
      any_idx_ff    <= any_idx_in;
      up_key_ff     <= up_key_in;
      up_tag_ff     <= up_tag_in;
      up_age_ff     <= up_age_in;
      up_idx_ff     <= up_idx_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_tag_ff    <= res_tag_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_occ_ff    <= rsp_occ_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         fill_ff      <= '0;
         counter_ff   <= '0;
         head_ff      <= '0;
         idx_ff       <= '0;
         rd_go_ff     <= 1'b0;
         s2_go_ff     <= 1'b0;
         any_have_ff  <= 1'b0;
         up_have_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         fill_ff      <= fill_in;
         counter_ff   <= counter_in;
         head_ff      <= head_in;
         idx_ff       <= idx_in;
         rd_go_ff     <= rd_go_in;
         s2_go_ff     <= s2_go_in;
         any_have_ff  <= any_have_in;
         up_have_ff   <= up_have_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_served_key = rsp_key_ff;
   assign rsp_served_tag = rsp_tag_ff;
   assign rsp_occupancy  = rsp_occ_ff;

   // Fill count tracks the valid bits exactly.
   `CERP_ASSERT(a_fill_matches_valid, clock, reset, ($countones(valid_ff) == fill_ff), "fill count and valid bits disagree")

   // A completed push adds exactly one pending request.
   `CERP_ASSERT(a_push_adds_one, clock, reset, ((state_ff == ST_PUSH) && push_slot_free) |=> (fill_ff == $past(fill_ff) + 1'b1), "push did not grow the store by one")

   // A pick always finds a winner, and the served key becomes the head.
   `CERP_ASSERT(a_pick_has_winner, clock, reset, (state_ff == ST_PICK) |-> any_have_ff, "pick with no candidate")
   `CERP_ASSERT(a_head_follows_served, clock, reset, (state_ff == ST_PICK) |=> (head_ff == res_key_ff), "head not moved to served key")

endmodule

`default_nettype wire

FILE: test/testbench.sv
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import cerp_pkg::*;

   // Number of random transactions after the directed tests.
   localparam int RANDOM_ITEMS   = 800;
   // Cycles without any transaction on either channel before giving up.
   // The limit must cover a full pop scan plus a stall run or a sender gap.
   localparam int WATCHDOG_LIMIT = 2000;
   // Cycles to wait after the last answer, in case something stray follows.
   localparam int TAIL_CYCLES    = CAPACITY + 8;
   localparam int PRINT_LIMIT    = 30;

   typedef enum int {
      STALL_NONE,
      STALL_SPARSE,
      STALL_RUNS
   } stall_mode_type;

   typedef enum int {
      KEYS_WIDE,
      KEYS_CLUSTERED,
      KEYS_NEAR_TOP,
      KEYS_NEAR_HEAD
   } key_mode_type;

   // One expected answer from the picker.
   typedef struct {
      status_type status;
      key_type    key;
      tag_type    tag;
      occ_type    occ;
   } outcome_type;

   logic         clock           = 1'b0;
   logic         reset           = 1'b1;
   logic         req_valid       = 1'b0;
   logic         req_stall;
   logic         req_action      = ACTION_PUSH;
   key_type      req_request_key = '0;
   tag_type      req_request_tag = '0;
   logic         rsp_valid;
   logic         rsp_stall       = 1'b0;
   logic [1:0]   rsp_status;
   key_type      rsp_served_key;
   tag_type      rsp_served_tag;
   occ_type      rsp_occupancy;

   // Scoreboard model of the pending-request store.
   key_type      slot_key   [CAPACITY];
   tag_type      slot_tag   [CAPACITY];
   stamp_type    slot_order [CAPACITY];
   logic         slot_live  [CAPACITY];
   stamp_type    push_count   = '0;
   key_type      arm_position = '0;
   int           live_count   = 0;

   // Answers still owed by the picker, oldest first.
   outcome_type  awaited_outcomes[$];

   int           mismatches       = 0;
   int           idle_cycles      = 0;
   int           burst_left       = 0;
   stall_mode_type stall_mode     = STALL_NONE;
   int           stall_phase_left = 0;
   int           stall_run_left   = 0;
   logic         stall_level      = 1'b0;

   always #6 clock = ~clock;

   circular_elevator_request_picker_core uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_request_key (req_request_key),
      .req_request_tag (req_request_tag),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_served_key  (rsp_served_key),
      .rsp_served_tag  (rsp_served_tag),
      .rsp_occupancy   (rsp_occupancy)
   );

   initial begin
      for (int i = 0; i < CAPACITY; i++) begin
         slot_live[i]  = 1'b0;
         slot_key[i]   = '0;
         slot_tag[i]   = '0;
         slot_order[i] = '0;
      end
   end

   // True when live slot a is to be served ahead of live slot b: lower key first,
   // and among equal keys the one that has waited longer (greater age) first.
   function automatic logic serves_first(int a, int b);
      stamp_type age_a;
      stamp_type age_b;
      if (slot_key[a] != slot_key[b])
         return slot_key[a] < slot_key[b];
      age_a = push_count - slot_order[a];
      age_b = push_count - slot_order[b];
      return age_a > age_b;
   endfunction

   // Apply one accepted transaction to the model and return the answer it owes.
   function automatic outcome_type predict_outcome(logic action, key_type key, tag_type tag);
      outcome_type res;
      int          free_slot;
      int          upward;
      int          lowest;
      int          pick;
      res.status = STATUS_PUSHED;
      res.key    = '0;
      res.tag    = '0;
      if (action == ACTION_PUSH) begin
         // Take the lowest-numbered free slot.
         free_slot = -1;
         for (int i = CAPACITY - 1; i >= 0; i--)
            if (!slot_live[i])
               free_slot = i;
         if (free_slot < 0) begin
            res.status = STATUS_FULL;
         end else begin
            slot_key[free_slot]   = key;
            slot_tag[free_slot]   = tag;
            slot_order[free_slot] = push_count;
            slot_live[free_slot]  = 1'b1;
            push_count++;
            live_count++;
         end
      end else begin
         // Find the first request at or above the head, and the lowest overall for wrap.
         upward = -1;
         lowest = -1;
         for (int i = 0; i < CAPACITY; i++) begin
            if (slot_live[i]) begin
               if (lowest < 0 || serves_first(i, lowest))
                  lowest = i;
               if (slot_key[i] >= arm_position && (upward < 0 || serves_first(i, upward)))
                  upward = i;
            end
         end
         if (lowest < 0) begin
            res.status = STATUS_EMPTY;
         end else begin
            pick = (upward >= 0) ? upward : lowest;
            res.status      = STATUS_SERVED;
            res.key         = slot_key[pick];
            res.tag         = slot_tag[pick];
            slot_live[pick] = 1'b0;
            arm_position    = slot_key[pick];
            live_count--;
         end
      end
      res.occ = occ_type'(live_count);
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t ns: mismatch on %0s: got %0h, want %0h", $time, what, got, want);
   endtask

   // Present one transaction and hold it until accepted. The sender works in bursts;
   // at the start of each burst it may drop valid for a random gap.
   task automatic send_item(logic action, key_type key, tag_type tag);
      int          gap;
      outcome_type owed;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_action      <= action;
      req_request_key <= key;
      req_request_tag <= tag;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      owed = predict_outcome(action, key, tag);
      awaited_outcomes = {awaited_outcomes, owed};
   endtask

   function automatic key_type random_key();
      key_mode_type mode;
      mode = key_mode_type'($urandom_range(0, 3));
      case (mode)
         KEYS_WIDE:      return {$urandom(), $urandom()};
         KEYS_CLUSTERED: return key_type'($urandom_range(0, 15));
         KEYS_NEAR_TOP:  return ~key_type'($urandom_range(0, 15));
         default:        return arm_position + key_type'($urandom_range(0, 4)) - key_type'(2);
      endcase
   endfunction

   // Pop before anything has been pushed.
   task automatic test_pop_when_empty();
      send_item(ACTION_POP, '1, '1);
   endtask

   // Smallest and largest keys and tags, served upward from a head of zero.
   task automatic test_extreme_keys();
      send_item(ACTION_PUSH, '0, '0);
      send_item(ACTION_PUSH, '1, '1);
      send_item(ACTION_PUSH, 64'h8000_0000_0000_0000, 16'h8000);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_POP, '0, '0);
   endtask

   // Equal keys leave in insertion order, including one pushed into a reused slot.
   task automatic test_equal_keys_in_order();
      send_item(ACTION_PUSH, 64'd42, 16'd1);
      send_item(ACTION_PUSH, 64'd41, 16'd9);
      send_item(ACTION_PUSH, 64'd42, 16'd2);
      send_item(ACTION_PUSH, 64'd42, 16'd3);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_PUSH, 64'd42, 16'd4);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_POP, '0, '0);
   endtask

   // Sweep upward, then wrap to the lowest key once nothing lies above the head.
   task automatic test_circular_wrap();
      send_item(ACTION_PUSH, 64'd300, 16'h0300);
      send_item(ACTION_PUSH, 64'd100, 16'h0100);
      send_item(ACTION_PUSH, 64'd200, 16'h0200);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_PUSH, 64'd150, 16'h0150);
      send_item(ACTION_POP, '0, '0);
      send_item(ACTION_POP, '0, '0);
   endtask

   // Fill every slot, push twice more for refusals, then drain past empty.
   task automatic test_fill_to_capacity();
      int pushes;
      pushes = CAPACITY - live_count + 2;
      repeat (pushes)
         send_item(ACTION_PUSH, key_type'($urandom_range(0, 7)), tag_type'($urandom()));
      repeat (CAPACITY + 1)
         send_item(ACTION_POP, random_key(), tag_type'($urandom()));
   endtask

   // Phases of push-heavy and pop-heavy traffic swing the store between empty and full.
   task automatic test_random_traffic();
      int   sent;
      int   push_share;
      int   phase_len;
      logic action;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 3))
            0:       push_share = 15;
            1:       push_share = 50;
            2:       push_share = 85;
            default: push_share = 100;
         endcase
         phase_len = $urandom_range(20, 90);
         if (phase_len > RANDOM_ITEMS - sent)
            phase_len = RANDOM_ITEMS - sent;
         repeat (phase_len) begin
            action = ($urandom_range(0, 99) < push_share) ? ACTION_PUSH : ACTION_POP;
            send_item(action, random_key(), tag_type'($urandom()));
            sent++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_pop_when_empty();
      test_extreme_keys();
      test_equal_keys_in_order();
      test_circular_wrap();
      test_fill_to_capacity();
      test_random_traffic();
      req_valid <= 1'b0;
      // Drain every owed answer, then watch a little longer for stray transactions.
      while (awaited_outcomes.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Result-side stall pattern: switch between no stall, sparse random stall and
   // long runs of stall or no stall.
   always @(posedge clock) begin
      if (stall_phase_left == 0) begin
         stall_mode       = stall_mode_type'($urandom_range(0, 2));
         stall_phase_left = $urandom_range(50, 400);
      end
      stall_phase_left--;
      case (stall_mode)
         STALL_NONE:   rsp_stall <= 1'b0;
         STALL_SPARSE: rsp_stall <= ($urandom_range(0, 3) == 0);
         default: begin
            if (stall_run_left == 0) begin
               stall_level    = 1'($urandom_range(0, 1));
               stall_run_left = $urandom_range(1, 24);
            end
            stall_run_left--;
            rsp_stall <= stall_level;
         end
      endcase
   end

   // Compare each accepted result transaction, field by field, with the oldest owed answer.
   // Values read here are those from before the edge, so there is no race with the block.
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_status, '0);
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", rsp_status, want.status);
            if (rsp_served_key !== want.key)
               report_mismatch("served_key", rsp_served_key, want.key);
            if (rsp_served_tag !== want.tag)
               report_mismatch("served_tag", rsp_served_tag, want.tag);
            if (rsp_occupancy !== want.occ)
               report_mismatch("occupancy", rsp_occupancy, want.occ);
         end
      end
   end

   // Watchdog: count cycles with no transaction on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+rtl
rtl/cerp_pkg.sv
rtl/cerp_ram.sv
rtl/circular_elevator_request_picker_core.sv
test/testbench.sv
